[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PBL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbl assertion failed");

// next-cycle implication, disabled while in reset
`define PBL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbl assertion failed");

`endif

[src/pbl_pkg.sv]
// types and constants of the page buffer frame table
package pbl_pkg;

  // default frame count and field widths
  localparam int unsigned FRAMES_DEF = 8;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned USERS_W    = 8;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned OUT_IDX_W  = 3;
  // index and count widths cover the largest supported frame count (64)
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [USERS_W-1:0] USERS_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ACCESS  = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FREE     = 3'd1,
    ST_VICTIM   = 3'd2,
    ST_NOVICTIM = 3'd3,
    ST_ABSENT   = 3'd4
  } status_e;

  // frame update issued to one cell after the search
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_HIT   = 3'd1,
    OP_FILL  = 3'd2,
    OP_REL   = 3'd3,
    OP_PIN   = 3'd4,
    OP_UNPIN = 3'd5
  } op_e;

  // search packet that walks the cell chain
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit_wm;
    logic               hit_dirty;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic               vu;
    logic [IDX_W-1:0]   vu_idx;
    logic [STAMP_W-1:0] vu_stamp;
    logic               vu_dirty;
    logic [PAGE_W-1:0]  vu_page;
    logic               va;
    logic [IDX_W-1:0]   va_idx;
    logic [STAMP_W-1:0] va_stamp;
    logic               va_dirty;
    logic [PAGE_W-1:0]  va_page;
  } pkt_t;

  typedef struct packed {
    logic               valid;
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [PAGE_W-1:0]  page;
    logic               wm;
    logic               pin;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

endpackage

[src/pbl_if.sv]
// request and response channel interfaces

interface pbl_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [pbl_pkg::PAGE_W-1:0] page_id;
  logic                      write_mode;
  logic                      pin_request;

  modport source (output valid, req_type, page_id, write_mode, pin_request, input ready);
  modport sink   (input valid, req_type, page_id, write_mode, pin_request, output ready);
endinterface

interface pbl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [pbl_pkg::OUT_IDX_W-1:0] frame_index;
  logic                          write_back_valid;
  logic [pbl_pkg::PAGE_W-1:0]    write_back_page;
  logic                          load_valid;

  modport source (output valid, status, frame_index, write_back_valid, write_back_page,
                  load_valid, input ready);
  modport sink   (input valid, status, frame_index, write_back_valid, write_back_page,
                  load_valid, output ready);
endinterface

[src/pbl_cell.sv]
// one frame of the table: holds the frame state and refines the search packet
module pbl_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pbl_pkg::CNT_W-1:0]   n_i,
  input  pbl_pkg::pkt_t               pkt_i,
  output pbl_pkg::pkt_t               pkt_o,
  input  pbl_pkg::cmd_t               cmd_i
);

  localparam logic [pbl_pkg::IDX_W-1:0] MY_IDX = pbl_pkg::IDX_W'(IDX);
  localparam logic [pbl_pkg::CNT_W-1:0] MY_POS = pbl_pkg::CNT_W'(IDX);

  logic                          valid_q, valid_d;
  logic [pbl_pkg::PAGE_W-1:0]    page_q, page_d;
  logic                          wm_q, wm_d;
  logic                          dirty_q, dirty_d;
  logic [pbl_pkg::USERS_W-1:0]   users_q, users_d;
  logic                          pinned_q, pinned_d;
  logic [pbl_pkg::STAMP_W-1:0]   last_q, last_d;
  pbl_pkg::pkt_t                 pkt_q, pkt_d;
  logic                          active;
  logic                          sel;

  assign active = (MY_POS < n_i);
  assign sel    = cmd_i.valid && (cmd_i.idx == MY_IDX);

  // search: first hit, first free frame, oldest zero-user frames
  always_comb begin
    pkt_d = pkt_i;
    if (pkt_i.valid && active) begin
      if (valid_q && (page_q == pkt_i.page) && !pkt_i.hit) begin
        pkt_d.hit       = 1'b1;
        pkt_d.hit_idx   = MY_IDX;
        pkt_d.hit_wm    = wm_q;
        pkt_d.hit_dirty = dirty_q;
      end
      if (!valid_q && !pkt_i.free) begin
        pkt_d.free     = 1'b1;
        pkt_d.free_idx = MY_IDX;
      end
      if (users_q == '0) begin
        if (!pinned_q && (!pkt_i.vu || (last_q < pkt_i.vu_stamp))) begin
          pkt_d.vu       = 1'b1;
          pkt_d.vu_idx   = MY_IDX;
          pkt_d.vu_stamp = last_q;
          pkt_d.vu_dirty = dirty_q;
          pkt_d.vu_page  = page_q;
        end
        if (!pkt_i.va || (last_q < pkt_i.va_stamp)) begin
          pkt_d.va       = 1'b1;
          pkt_d.va_idx   = MY_IDX;
          pkt_d.va_stamp = last_q;
          pkt_d.va_dirty = dirty_q;
          pkt_d.va_page  = page_q;
        end
      end
    end
  end

  // frame update from the controller
  always_comb begin
    valid_d  = valid_q;
    page_d   = page_q;
    wm_d     = wm_q;
    dirty_d  = dirty_q;
    users_d  = users_q;
    pinned_d = pinned_q;
    last_d   = last_q;
    if (sel) begin
      case (cmd_i.op)
        pbl_pkg::OP_HIT: begin
          if (!wm_q && (users_q != pbl_pkg::USERS_MAX)) begin
            users_d = users_q + 1'b1;
          end
          last_d  = cmd_i.stamp;
          wm_d    = cmd_i.wm;
          dirty_d = cmd_i.wm;
          if (cmd_i.pin) begin
            pinned_d = 1'b1;
          end
        end
        pbl_pkg::OP_FILL: begin
          valid_d  = 1'b1;
          page_d   = cmd_i.page;
          wm_d     = cmd_i.wm;
          dirty_d  = cmd_i.wm;
          users_d  = pbl_pkg::USERS_W'(1);
          pinned_d = cmd_i.pin;
          last_d   = cmd_i.stamp;
        end
        pbl_pkg::OP_REL: begin
          if (wm_q || dirty_q) begin
            dirty_d = 1'b0;
          end
          if (pinned_q && (users_q == pbl_pkg::USERS_W'(1))) begin
            pinned_d = 1'b0;
          end
          if (users_q != '0) begin
            users_d = users_q - 1'b1;
          end
        end
        pbl_pkg::OP_PIN: begin
          pinned_d = 1'b1;
        end
        pbl_pkg::OP_UNPIN: begin
          pinned_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // frame state and packet stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      page_q   <= '0;
      wm_q     <= 1'b0;
      dirty_q  <= 1'b0;
      users_q  <= '0;
      pinned_q <= 1'b0;
      last_q   <= '0;
      pkt_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      page_q   <= page_d;
      wm_q     <= wm_d;
      dirty_q  <= dirty_d;
      users_q  <= users_d;
      pinned_q <= pinned_d;
      last_q   <= last_d;
      pkt_q    <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

[src/pbl_ctrl.sv]
// request sequencing, final decision, access clock and result register
module pbl_ctrl #(
  parameter int unsigned FRAMES = pbl_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pbl_req_if.sink                     req_i,
  pbl_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [pbl_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic [pbl_pkg::CNT_W-1:0]   n_o,
  output pbl_pkg::pkt_t               launch_o,
  input  pbl_pkg::pkt_t               fin_i,
  output pbl_pkg::cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE
  } state_e;

  localparam logic [pbl_pkg::CNT_W-1:0] N_MAX = pbl_pkg::CNT_W'(FRAMES);

  state_e                       state_q;
  logic [pbl_pkg::CFG_W-1:0]    cfg_q;
  pbl_pkg::req_e                req_q;
  logic                         wm_q;
  logic                         pin_q;
  logic [pbl_pkg::STAMP_W-1:0]  clock_q;
  pbl_pkg::pkt_t                launch_q, launch_d;
  pbl_pkg::pkt_t                fin_q;
  pbl_pkg::cmd_t                cmd_q;
  logic                         rsp_valid_q;
  pbl_pkg::status_e             status_q;
  logic [pbl_pkg::IDX_W-1:0]    idx_q;
  logic                         wbv_q;
  logic [pbl_pkg::PAGE_W-1:0]   wbp_q;
  logic                         ldv_q;

  logic [pbl_pkg::CNT_W-1:0]    cfg_ext;
  logic                         req_fire;
  logic                         rsp_fire;
  logic                         go;
  logic [pbl_pkg::STAMP_W-1:0]  clock_nx;
  pbl_pkg::status_e             dec_status;
  logic [pbl_pkg::IDX_W-1:0]    dec_idx;
  logic                         dec_wbv;
  logic [pbl_pkg::PAGE_W-1:0]   dec_wbp;
  logic                         dec_ldv;
  pbl_pkg::cmd_t                dec_cmd;

  // clamp of the active frame count
  assign cfg_ext = pbl_pkg::CNT_W'(cfg_q);
  always_comb begin
    if (cfg_ext == '0) begin
      n_o = pbl_pkg::CNT_W'(1);
    end else if (cfg_ext > N_MAX) begin
      n_o = N_MAX;
    end else begin
      n_o = cfg_ext;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_valid_q && rsp_o.ready;
  assign go          = (state_q == S_DECIDE) && (!rsp_valid_q || rsp_o.ready);
  assign clock_nx    = clock_q + 1'b1;

  // launch packet of an accepted request
  always_comb begin
    launch_d       = '0;
    launch_d.valid = req_fire;
    launch_d.page  = req_i.page_id;
  end

  // decision from the finished search packet
  always_comb begin
    dec_status    = pbl_pkg::ST_DONE;
    dec_idx       = '0;
    dec_wbv       = 1'b0;
    dec_wbp       = '0;
    dec_ldv       = 1'b0;
    dec_cmd       = '0;
    dec_cmd.op    = pbl_pkg::OP_NONE;
    dec_cmd.page  = fin_q.page;
    dec_cmd.wm    = wm_q;
    dec_cmd.pin   = pin_q;
    dec_cmd.stamp = clock_nx;
    if (req_q == pbl_pkg::REQ_ACCESS) begin
      if (fin_q.hit) begin
        dec_idx       = fin_q.hit_idx;
        dec_wbv       = fin_q.hit_wm;
        dec_wbp       = fin_q.hit_wm ? fin_q.page : '0;
        dec_ldv       = fin_q.hit_wm;
        dec_cmd.valid = 1'b1;
        dec_cmd.op    = pbl_pkg::OP_HIT;
        dec_cmd.idx   = fin_q.hit_idx;
      end else if (fin_q.free) begin
        dec_status    = pbl_pkg::ST_FREE;
        dec_idx       = fin_q.free_idx;
        dec_ldv       = 1'b1;
        dec_cmd.valid = 1'b1;
        dec_cmd.op    = pbl_pkg::OP_FILL;
        dec_cmd.idx   = fin_q.free_idx;
      end else if (fin_q.vu) begin
        dec_status    = pbl_pkg::ST_VICTIM;
        dec_idx       = fin_q.vu_idx;
        dec_wbv       = fin_q.vu_dirty;
        dec_wbp       = fin_q.vu_dirty ? fin_q.vu_page : '0;
        dec_ldv       = 1'b1;
        dec_cmd.valid = 1'b1;
        dec_cmd.op    = pbl_pkg::OP_FILL;
        dec_cmd.idx   = fin_q.vu_idx;
      end else if (fin_q.va) begin
        dec_status    = pbl_pkg::ST_VICTIM;
        dec_idx       = fin_q.va_idx;
        dec_wbv       = fin_q.va_dirty;
        dec_wbp       = fin_q.va_dirty ? fin_q.va_page : '0;
        dec_ldv       = 1'b1;
        dec_cmd.valid = 1'b1;
        dec_cmd.op    = pbl_pkg::OP_FILL;
        dec_cmd.idx   = fin_q.va_idx;
      end else begin
        dec_status = pbl_pkg::ST_NOVICTIM;
      end
    end else if (!fin_q.hit) begin
      dec_status = pbl_pkg::ST_ABSENT;
    end else begin
      dec_idx       = fin_q.hit_idx;
      dec_cmd.valid = 1'b1;
      dec_cmd.idx   = fin_q.hit_idx;
      case (req_q)
        pbl_pkg::REQ_RELEASE: begin
          dec_wbv    = fin_q.hit_wm || fin_q.hit_dirty;
          dec_wbp    = dec_wbv ? fin_q.page : '0;
          dec_cmd.op = pbl_pkg::OP_REL;
        end
        pbl_pkg::REQ_PIN: begin
          dec_cmd.op = pbl_pkg::OP_PIN;
        end
        pbl_pkg::REQ_UNPIN: begin
          dec_cmd.op = pbl_pkg::OP_UNPIN;
        end
        default: begin
          dec_cmd.valid = 1'b0;
        end
      endcase
    end
  end

  // sequencer, clock, command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= pbl_pkg::CFG_RESET;
      clock_q     <= '0;
      launch_q    <= '0;
      cmd_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      launch_q <= launch_d;
      if (go) begin
        cmd_q <= dec_cmd;
      end else begin
        cmd_q.valid <= 1'b0;
      end
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (fin_i.valid) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (go) begin
            if (req_q == pbl_pkg::REQ_ACCESS) begin
              clock_q <= clock_nx;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request fields, final packet and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= pbl_pkg::req_e'(req_i.req_type);
      wm_q  <= req_i.write_mode;
      pin_q <= req_i.pin_request;
    end
    if ((state_q == S_SEARCH) && fin_i.valid) begin
      fin_q <= fin_i;
    end
    if (go) begin
      status_q <= dec_status;
      idx_q    <= dec_idx;
      wbv_q    <= dec_wbv;
      wbp_q    <= dec_wbp;
      ldv_q    <= dec_ldv;
    end
  end

  assign launch_o                = launch_q;
  assign cmd_o                   = cmd_q;
  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.status            = status_q;
  assign rsp_o.frame_index       = idx_q[pbl_pkg::OUT_IDX_W-1:0];
  assign rsp_o.write_back_valid  = wbv_q;
  assign rsp_o.write_back_page   = wbp_q;
  assign rsp_o.load_valid        = ldv_q;

endmodule

[src/page_buffer_lru_pin_manager.sv]
// page buffer frame table: controller and a chain of frame cells
//
//   channel  dir  handshake       payload
//   req_i    in   valid / ready   req_type, page_id, write_mode, pin_request
//   rsp_o    out  valid / ready   status, frame_index, write_back_*, load_valid
//   cfg      in   cfg_we_i        cfg_wdata_i (active_frames)
//
// one request at a time; a search packet walks the cell chain one frame per cycle,
// so the result is registered once the packet has left the last frame and the decision is made,
// and the next request is taken once the controller is back in idle after the decision
// a new request is taken while the previous result still waits on rsp_o; the
// decision stalls only if that result has not gone out yet
// reset clears all frames to free, the access clock to zero and active_frames to 8
module page_buffer_lru_pin_manager #(
  parameter int unsigned FRAMES = pbl_pkg::FRAMES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pbl_req_if.sink                   req_i,
  pbl_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [pbl_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [pbl_pkg::CNT_W-1:0] n;
  pbl_pkg::pkt_t             pkt [0:FRAMES];
  pbl_pkg::cmd_t             cmd;

  // sequencer and result register
  pbl_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .n_o         (n),
    .launch_o    (pkt[0]),
    .fin_i       (pkt[FRAMES]),
    .cmd_o       (cmd)
  );

  // frame chain
  for (genvar i = 0; i < FRAMES; i++) begin : g_frame
    pbl_cell #(
      .IDX (i)
    ) u_frame (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .n_i    (n),
      .pkt_i  (pkt[i]),
      .pkt_o  (pkt[i+1]),
      .cmd_i  (cmd)
    );
  end

endmodule

[src/pbl_checker.sv]
// port-level checks of the frame table, bound to the top level
`include "assert_macros.svh"

module pbl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [2:0]                    status_i,
  input logic [pbl_pkg::OUT_IDX_W-1:0] frame_index_i,
  input logic                          wb_valid_i,
  input logic [pbl_pkg::PAGE_W-1:0]    wb_page_i,
  input logic                          load_valid_i
);

  // a stalled result holds
  `PBL_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(frame_index_i) && $stable(wb_page_i))

  // one request in flight: ready drops after each transfer
  `PBL_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // no victim and not resident carry no frame, load or write-back
  `PBL_ASSERT_IMP(a_empty_result, clk_i, rst_ni, rsp_valid_i && (status_i == pbl_pkg::ST_NOVICTIM || status_i == pbl_pkg::ST_ABSENT), !load_valid_i && !wb_valid_i && (frame_index_i == '0))

  // write-back page is zero without a write-back
  `PBL_ASSERT_IMP(a_wb_page_zero, clk_i, rst_ni, rsp_valid_i && !wb_valid_i, wb_page_i == '0)

  // a filled frame always loads its page
  `PBL_ASSERT_IMP(a_fill_loads, clk_i, rst_ni, rsp_valid_i && (status_i == pbl_pkg::ST_FREE || status_i == pbl_pkg::ST_VICTIM), load_valid_i)

endmodule

bind page_buffer_lru_pin_manager pbl_checker u_pbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .frame_index_i (rsp_o.frame_index),
  .wb_valid_i    (rsp_o.write_back_valid),
  .wb_page_i     (rsp_o.write_back_page),
  .load_valid_i  (rsp_o.load_valid)
);

[tb/sv/tb.sv]
// self-checking testbench for the page buffer frame table with lru and pin counts
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAME_CNT     = 8;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOT_PHASE     = 10;
  localparam int unsigned PHASE_ITEMS   = 112;
  localparam int unsigned HOT_ITEMS     = 400;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    pbl_pkg::req_e kind;
    logic [15:0]   page;
    logic          wm;
    logic          pin;
  } page_req_t;

  typedef struct {
    pbl_pkg::status_e status;
    logic [2:0]       frame;
    logic             wb;
    logic [15:0]      wb_page;
    logic             load;
  } frame_rsp_t;

  typedef struct {
    pbl_pkg::req_e kind;
    logic [15:0]   page;
    logic          wm;
    logic          pin;
    bit            typed;
    frame_rsp_t    want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [pbl_pkg::CFG_W-1:0] cfg_wdata_i;

  pbl_req_if req_if ();
  pbl_rsp_if rsp_if ();

  page_buffer_lru_pin_manager dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame table as the block should hold it
  logic [15:0] fr_page   [FRAME_CNT];
  bit          fr_valid  [FRAME_CNT];
  bit          fr_wm     [FRAME_CNT];
  bit          fr_dirty  [FRAME_CNT];
  logic [7:0]  fr_users  [FRAME_CNT];
  bit          fr_pinned [FRAME_CNT];
  logic [31:0] fr_stamp  [FRAME_CNT];
  logic [31:0] access_clock;
  logic [3:0]  active_reg;

  frame_rsp_t pending_frame_rsp [$];
  int         mismatches;
  bit         calm;

  // directed requests; typed rows carry their expected response
  dir_row_t dir_rows [24] = '{
    '{pbl_pkg::REQ_RELEASE, 16'h0005, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_ABSENT, 3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_PIN,     16'h0005, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_ABSENT, 3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_UNPIN,   16'h0000, 1'b1, 1'b1, 1'b1,
      '{pbl_pkg::ST_ABSENT, 3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h0000, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_FREE,   3'd0, 1'b0, 16'h0000, 1'b1}},
    '{pbl_pkg::REQ_ACCESS,  16'hFFFF, 1'b1, 1'b1, 1'b1,
      '{pbl_pkg::ST_FREE,   3'd1, 1'b0, 16'h0000, 1'b1}},
    // hit on a write-mode frame: written back and reloaded
    '{pbl_pkg::REQ_ACCESS,  16'hFFFF, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_DONE,   3'd1, 1'b1, 16'hFFFF, 1'b1}},
    '{pbl_pkg::REQ_ACCESS,  16'h0000, 1'b1, 1'b1, 1'b1,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_PIN,     16'h0000, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_UNPIN,   16'hFFFF, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_DONE,   3'd1, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_RELEASE, 16'hFFFF, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_RELEASE, 16'h0000, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    // last user leaves a pinned frame: pin drops
    '{pbl_pkg::REQ_RELEASE, 16'h0000, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    // user count already zero: stays at zero
    '{pbl_pkg::REQ_RELEASE, 16'h0000, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    // write-mode hit with zero users leaves the frame dirty and unused
    '{pbl_pkg::REQ_ACCESS,  16'h0000, 1'b1, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h1234, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'hA5A5, 1'b1, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h5A5A, 1'b0, 1'b1, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h8000, 1'b1, 1'b1, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h0001, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h7FFF, 1'b1, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    // table full: clean victim, then dirty victim
    '{pbl_pkg::REQ_ACCESS,  16'h0100, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_ACCESS,  16'h0200, 1'b0, 1'b0, 1'b0,
      '{pbl_pkg::ST_DONE,   3'd0, 1'b0, 16'h0000, 1'b0}},
    // every frame in use
    '{pbl_pkg::REQ_ACCESS,  16'h0300, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_NOVICTIM, 3'd0, 1'b0, 16'h0000, 1'b0}},
    '{pbl_pkg::REQ_RELEASE, 16'h0300, 1'b0, 1'b0, 1'b1,
      '{pbl_pkg::ST_ABSENT, 3'd0, 1'b0, 16'h0000, 1'b0}}
  };

  // active frame setting of each random phase
  logic [3:0] cfg_plan [12] = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd8,
                                4'd5, 4'd4, 4'd7, 4'd6, 4'd1, 4'd8};

  function automatic int frames_in_use();
    if (active_reg < 4'd1) return 1;
    if (active_reg > FRAME_CNT) return FRAME_CNT;
    return int'(active_reg);
  endfunction

  // oldest stamp among zero-user frames, lowest index on ties
  function automatic int lru_victim(input int n, input bit need_unpinned);
    int best = -1;
    for (int i = 0; i < n; i++) begin
      if (fr_users[i] != 8'd0) continue;
      if (need_unpinned && fr_pinned[i]) continue;
      if (best < 0 || fr_stamp[i] < fr_stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic void fill_frame(input int f, input page_req_t r);
    fr_valid[f]  = 1'b1;
    fr_page[f]   = r.page;
    fr_wm[f]     = r.wm;
    fr_dirty[f]  = r.wm;
    fr_users[f]  = 8'd1;
    fr_pinned[f] = r.pin;
    fr_stamp[f]  = access_clock;
  endfunction

  // expected response of one request; updates the frame table
  function automatic frame_rsp_t predict_frame_rsp(input page_req_t r);
    frame_rsp_t o;
    int n;
    int f;
    n = frames_in_use();
    o = '{pbl_pkg::ST_DONE, 3'd0, 1'b0, 16'h0000, 1'b0};
    f = -1;
    for (int i = 0; i < n; i++)
      if (f < 0 && fr_valid[i] && fr_page[i] == r.page) f = i;

    if (r.kind == pbl_pkg::REQ_ACCESS) begin
      access_clock = access_clock + 32'd1;
      if (f >= 0) begin
        if (fr_wm[f]) begin
          o.wb      = 1'b1;
          o.wb_page = fr_page[f];
          o.load    = 1'b1;
        end else if (fr_users[f] != 8'hFF) begin
          fr_users[f] = fr_users[f] + 8'd1;
        end
        fr_stamp[f] = access_clock;
        fr_wm[f]    = r.wm;
        fr_dirty[f] = r.wm;
        if (r.pin) fr_pinned[f] = 1'b1;
        o.frame = 3'(f);
      end else begin
        for (int i = 0; i < n; i++)
          if (f < 0 && !fr_valid[i]) f = i;
        if (f >= 0) begin
          fill_frame(f, r);
          o.status = pbl_pkg::ST_FREE;
          o.frame  = 3'(f);
          o.load   = 1'b1;
        end else begin
          f = lru_victim(n, 1'b1);
          if (f < 0) f = lru_victim(n, 1'b0);
          if (f < 0) begin
            o.status = pbl_pkg::ST_NOVICTIM;
          end else begin
            if (fr_dirty[f]) begin
              o.wb      = 1'b1;
              o.wb_page = fr_page[f];
            end
            fill_frame(f, r);
            o.status = pbl_pkg::ST_VICTIM;
            o.frame  = 3'(f);
            o.load   = 1'b1;
          end
        end
      end
    end else if (f < 0) begin
      o.status = pbl_pkg::ST_ABSENT;
    end else begin
      o.frame = 3'(f);
      case (r.kind)
        pbl_pkg::REQ_RELEASE: begin
          if (fr_wm[f] || fr_dirty[f]) begin
            o.wb        = 1'b1;
            o.wb_page   = fr_page[f];
            fr_dirty[f] = 1'b0;
          end
          if (fr_pinned[f] && fr_users[f] == 8'd1) fr_pinned[f] = 1'b0;
          if (fr_users[f] != 8'd0) fr_users[f] = fr_users[f] - 8'd1;
        end
        pbl_pkg::REQ_PIN: fr_pinned[f] = 1'b1;
        default: fr_pinned[f] = 1'b0;
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // drive one request and wait for its transfer
  task automatic send_page_req(input page_req_t r, input bit typed, input frame_rsp_t want);
    frame_rsp_t pred;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.kind;
    req_if.page_id     <= r.page;
    req_if.write_mode  <= r.wm;
    req_if.pin_request <= r.pin;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    pred = predict_frame_rsp(r);
    if (typed) pred = want;
    pending_frame_rsp = {pending_frame_rsp, pred};
  endtask

  // random idle burst on the request side
  task automatic sender_gap(input int odds);
    if (!calm && odds > 0 && $urandom_range(0, 7) < odds) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // write the register once all responses are back
  task automatic write_active_frames(input logic [3:0] v);
    req_if.valid <= 1'b0;
    while (pending_frame_rsp.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    active_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  // stimulus: reset, directed table, random phases
  initial begin : stimulus
    page_req_t   item;
    frame_rsp_t  no_want;
    logic [15:0] pool [12];
    int          n;
    int          pool_n;
    int          gap_odds;
    int          items;
    int          roll;
    int          sel;
    bit          hot;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= pbl_pkg::REQ_ACCESS;
    req_if.page_id     <= '0;
    req_if.write_mode  <= 1'b0;
    req_if.pin_request <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    no_want = '{pbl_pkg::ST_DONE, 3'd0, 1'b0, 16'h0000, 1'b0};
    for (int i = 0; i < FRAME_CNT; i++) begin
      fr_page[i]   = '0;
      fr_valid[i]  = 1'b0;
      fr_wm[i]     = 1'b0;
      fr_dirty[i]  = 1'b0;
      fr_users[i]  = '0;
      fr_pinned[i] = 1'b0;
      fr_stamp[i]  = '0;
    end
    access_clock = '0;
    active_reg   = pbl_pkg::CFG_RESET;
    mismatches   = 0;
    calm         = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset setting of eight frames
    foreach (dir_rows[k]) begin
      item = '{dir_rows[k].kind, dir_rows[k].page, dir_rows[k].wm, dir_rows[k].pin};
      sender_gap(2);
      send_page_req(item, dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases, each with its own page pool of three pages more than the frame count, two in the hot phase
    foreach (cfg_plan[p]) begin
      write_active_frames(cfg_plan[p]);
      hot  = (p == HOT_PHASE);
      calm = (p == $size(cfg_plan) - 1);
      n = frames_in_use();
      pool_n = hot ? 2 : n + 3;
      for (int j = 0; j < pool_n; j++) pool[j] = 16'($urandom);
      // hammer the resident page so its user count saturates
      if (hot && fr_valid[0]) pool[0] = fr_page[0];
      gap_odds = $urandom_range(0, 4);
      items = hot ? HOT_ITEMS : PHASE_ITEMS;
      repeat (items) begin
        roll = $urandom_range(0, 99);
        if (hot)
          item.kind = roll < 80 ? pbl_pkg::REQ_ACCESS : roll < 95 ? pbl_pkg::REQ_RELEASE :
                      roll < 98 ? pbl_pkg::REQ_PIN : pbl_pkg::REQ_UNPIN;
        else
          item.kind = roll < 45 ? pbl_pkg::REQ_ACCESS : roll < 75 ? pbl_pkg::REQ_RELEASE :
                      roll < 87 ? pbl_pkg::REQ_PIN : pbl_pkg::REQ_UNPIN;
        sel = hot ? int'($urandom_range(0, 9) == 0) : $urandom_range(0, pool_n - 1);
        item.page = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[sel];
        item.wm   = hot ? ($urandom_range(0, 19) == 0) : 1'($urandom_range(0, 1));
        item.pin  = ($urandom_range(0, 3) == 0);
        sender_gap(gap_odds);
        send_page_req(item, 1'b0, no_want);
      end
    end

    // drain and let any stray response show up
    req_if.valid <= 1'b0;
    while (pending_frame_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[page_buffer_lru_pin_manager] OK");
    end else begin
      $display("[page_buffer_lru_pin_manager] ERROR");
    end
    $finish;
  end

  // response side: check each transfer, stall in random bursts
  initial begin : response_sink
    frame_rsp_t want;
    int         stall_left;
    int         rx_odds;
    int         cycle_cnt;
    bit         bad;
    stall_left = 0;
    rx_odds    = 2;
    cycle_cnt  = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_frame_rsp.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending, status %0d frame %0d",
                                    rsp_if.status, rsp_if.frame_index));
        end else begin
          want = pending_frame_rsp.pop_front();
          bad = (rsp_if.status !== want.status) || (rsp_if.frame_index !== want.frame) ||
                (rsp_if.write_back_valid !== want.wb) ||
                (rsp_if.write_back_page !== want.wb_page) || (rsp_if.load_valid !== want.load);
          if (bad)
            report_mismatch($sformatf(
              "exp status %0d frame %0d wb %0b page %h load %0b, got %0d %0d %0b %h %0b",
              want.status, want.frame, want.wb, want.wb_page, want.load,
              rsp_if.status, rsp_if.frame_index, rsp_if.write_back_valid,
              rsp_if.write_back_page, rsp_if.load_valid));
        end
      end
      // stall odds change now and then, zero odds gives stretches with no stall
      cycle_cnt++;
      if (cycle_cnt % 128 == 0) rx_odds = $urandom_range(0, 3);
      if (stall_left > 0 && !calm) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 15) < rx_odds) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("[page_buffer_lru_pin_manager] ERROR");
    $finish;
  end

endmodule
